>>> rtl/core/tlb_lru_lookup_insert_unit_macros.svh
// Assertion macros for the TLB lookup/insert unit checker.
// Included by the checker file; no other dependencies.
`ifndef TLB_LRU_LOOKUP_INSERT_UNIT_MACROS_SVH
`define TLB_LRU_LOOKUP_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TLBL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlbl assertion failed");

// Next-cycle implication, off during reset.
`define TLBL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlbl assertion failed");

// Next-cycle implication that also covers reset itself.
`define TLBL_ASSERT_NXT_ALL(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tlbl assertion failed");

`endif

>>> rtl/core/tlbl_pkg.sv
// Shared types and constants for the TLB lookup/insert unit.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package tlbl_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 20;
   localparam int STAMP_BITS_DEF = 32;

   localparam int CFG_W      = 5;
   localparam int CFG_RESET  = 16;
   localparam int COUNT_W    = 32;
   localparam int SLOT_W     = 4;
   // hit, slot, hit_count, miss_count packed, rounded up to bytes
   localparam int RSP_FIELDS_W = 1 + SLOT_W + COUNT_W + COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // per-cell control from the sequencer
   typedef struct packed {
      logic active;   // cell is inside the placement range
      logic wr_en;    // refresh stamp this cycle
      logic wr_key;   // also store the key (fill / replace)
   } tlbl_cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/tlb_lru_lookup_insert_unit.sv
// Fully associative TLB with LRU replacement, built as a row of entry cells.
// Depends on tlbl_pkg and tlbl_cell.
//
// Usage:
//  - req channel: one transfer per operation. req_tuser = action
//    (0 lookup, 1 insert/refresh), req_tdata = page key.
//  - rsp channel: exactly one transfer per request, in order, carrying
//    hit, slot, running hit count and running miss count.
//  - csr port: csr_wr_en/csr_wr_data write the active entry count (1..16,
//    0 acts as 1, larger than ENTRIES acts as ENTRIES). Write only while idle.
// Timing:
//  - lookups, hits and insert refreshes: the key compare runs in ST_MATCH and
//    the result is registered from ST_WRITE, where the next request is taken.
//  - insert miss: the oldest/empty search walks the cell chain one cell per
//    cycle, so the result is registered only once ST_SWEEP has reached the
//    last cell, and the next request is taken then.
//  - a stalled rsp holds its output register; one finished request may wait
//    there while the next request is taken and searched, then the unit waits.
// Reset: synchronous; all entries empty, counters and use clock zero,
//  entry count 16. No clearing pass is needed.
`default_nettype none

module tlb_lru_lookup_insert_unit #(
   parameter int ENTRIES    = tlbl_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = tlbl_pkg::KEY_BITS_DEF,
   parameter int STAMP_BITS = tlbl_pkg::STAMP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = page_key, tuser = action
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((KEY_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                req_tuser,
   // response: tdata = hit, slot[3:0], hit_count[31:0], miss_count[31:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tlbl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // config: active entry count
   input  logic                                csr_wr_en,
   input  logic [tlbl_pkg::CFG_W-1:0]          csr_wr_data
);
   import tlbl_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SWEEP,
      ST_WRITE
   } state_type;

   state_type             state_ff, state_in;
   logic                  action_ff, action_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [STAMP_BITS-1:0] use_clock_ff, use_clock_in;
   logic [COUNT_W-1:0]    hits_ff, hits_in;
   logic [COUNT_W-1:0]    misses_ff, misses_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0]      csr_entries_ff, csr_entries_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  write_go;
   logic [ENTRIES-1:0]    match_vec;
   logic                  any_match;
   logic [IDX_W-1:0]      match_idx;
   logic [COUNT_W-1:0]    hits_sat;
   logic [COUNT_W-1:0]    misses_sat;
   logic [SLOT_W+IDX_W-1:0] slot_ext;

   tlbl_cell_ctl_type     cell_ctl   [ENTRIES];
   logic                  carry_found[ENTRIES];
   logic [IDX_W-1:0]      carry_idx  [ENTRIES];
   logic [STAMP_BITS-1:0] carry_stamp[ENTRIES];

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign write_go   = (state_ff == ST_WRITE) && out_free;
   assign req_tready = (state_ff == ST_IDLE) || write_go;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Cell row. Search carry enters cell 0 with "nothing empty, oldest = 0"
   // and moves one cell per clock toward the last cell.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic                  p_found;
      logic [IDX_W-1:0]      p_idx;
      logic [STAMP_BITS-1:0] p_stamp;

      if (g == 0) begin : g_seed
         assign p_found = 1'b0;
         assign p_idx   = '0;
         assign p_stamp = '1;
      end else begin : g_link
         assign p_found = carry_found[g-1];
         assign p_idx   = carry_idx[g-1];
         assign p_stamp = carry_stamp[g-1];
      end

      // entry 0 always takes part; others when below the configured count
      assign cell_ctl[g].active = (g == 0) || (int'(csr_entries_ff) > g);
      assign cell_ctl[g].wr_en  = write_go && (hit_ff || action_ff)
                                  && (slot_ff == IDX_W'(g));
      assign cell_ctl[g].wr_key = !hit_ff;

      tlbl_cell #(
         .IDX_W      (IDX_W),
         .KEY_BITS   (KEY_BITS),
         .STAMP_BITS (STAMP_BITS),
         .CELL_IDX   (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (cell_ctl[g]),
         .key_in         (key_ff),
         .stamp_in       (use_clock_ff),
         .match          (match_vec[g]),
         .prev_found     (p_found),
         .prev_idx       (p_idx),
         .prev_stamp     (p_stamp),
         .carry_found_ff (carry_found[g]),
         .carry_idx_ff   (carry_idx[g]),
         .carry_stamp_ff (carry_stamp[g])
      );
   end

   // lowest matching index (keys are unique among valid entries anyway)
   always_comb begin
      match_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = IDX_W'(i);
         end
      end
   end
   assign any_match = |match_vec;

   // saturating counters and the 4-bit slot view
   assign hits_sat   = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
   assign misses_sat = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
   assign slot_ext   = {{SLOT_W{1'b0}}, slot_ff};

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      key_in         = key_ff;
      use_clock_in   = use_clock_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      sweep_in       = sweep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      csr_entries_in = csr_wr_en ? csr_wr_data : csr_entries_ff;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_MATCH: begin
            hit_in  = any_match;
            slot_in = any_match ? match_idx : '0;
            if (!any_match && action_ff) begin
               sweep_in = '0;
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            // last cell's carry covers the whole row once the chain has filled
            if (sweep_ff == IDX_W'(ENTRIES - 1)) begin
               slot_in  = carry_idx[ENTRIES-1];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               if (hit_ff) begin
                  hits_in = hits_sat;
               end else begin
                  misses_in = misses_sat;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({
                  hit_ff ? misses_ff : misses_sat,
                  hit_ff ? hits_sat  : hits_ff,
                  slot_ext[SLOT_W-1:0],
                  hit_ff});
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new request: latch it and advance the use clock
      if (req_accept) begin
         action_in    = req_tuser;
         key_in       = req_tdata[KEY_BITS-1:0];
         use_clock_in = (use_clock_ff == '1) ? use_clock_ff : use_clock_ff + 1'b1;
         state_in     = ST_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         use_clock_ff   <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         csr_entries_ff <= CFG_W'(CFG_RESET);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         use_clock_ff   <= use_clock_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         csr_entries_ff <= csr_entries_in;
      end
      action_ff   <= action_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      sweep_ff    <= sweep_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/tlbl_cell.sv
// One TLB entry: key and use stamp, key compare, and one stage of the
// oldest/empty search chain. Depends on tlbl_pkg.
`default_nettype none

module tlbl_cell #(
   parameter int IDX_W      = 4,
   parameter int KEY_BITS   = 20,
   parameter int STAMP_BITS = 32,
   parameter int CELL_IDX   = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlbl_pkg::tlbl_cell_ctl_type   ctl,
   input  logic [KEY_BITS-1:0]           key_in,
   input  logic [STAMP_BITS-1:0]         stamp_in,
   output logic                          match,
   input  logic                          prev_found,
   input  logic [IDX_W-1:0]              prev_idx,
   input  logic [STAMP_BITS-1:0]         prev_stamp,
   output logic                          carry_found_ff,
   output logic [IDX_W-1:0]              carry_idx_ff,
   output logic [STAMP_BITS-1:0]         carry_stamp_ff
);
   import tlbl_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic [KEY_BITS-1:0]   key_in_nx;
   logic [STAMP_BITS-1:0] stamp_in_nx;
   logic                  carry_found_in;
   logic [IDX_W-1:0]      carry_idx_in;
   logic [STAMP_BITS-1:0] carry_stamp_in;

   assign match = (stamp_ff != '0) && (key_ff == key_in);

   // search stage: first empty wins, else strictly older stamp wins
   always_comb begin
      carry_found_in = prev_found;
      carry_idx_in   = prev_idx;
      carry_stamp_in = prev_stamp;
      if (ctl.active && !prev_found) begin
         if (stamp_ff == '0) begin
            carry_found_in = 1'b1;
            carry_idx_in   = IDX_W'(CELL_IDX);
         end else if (stamp_ff < prev_stamp) begin
            carry_idx_in   = IDX_W'(CELL_IDX);
            carry_stamp_in = stamp_ff;
         end
      end
   end

   assign stamp_in_nx = ctl.wr_en ? stamp_in : stamp_ff;
   assign key_in_nx   = (ctl.wr_en && ctl.wr_key) ? key_in : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else begin
         stamp_ff <= stamp_in_nx;
      end
      key_ff         <= key_in_nx;
      carry_found_ff <= carry_found_in;
      carry_idx_ff   <= carry_idx_in;
      carry_stamp_ff <= carry_stamp_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/tlbl_chk.sv
// Port-level checker for the TLB lookup/insert unit, plus its bind.
// Depends on tlbl_pkg and tlb_lru_lookup_insert_unit_macros.svh.
`default_nettype none
`include "tlb_lru_lookup_insert_unit_macros.svh"

module tlbl_chk (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [tlbl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tlbl_pkg::*;

   localparam int HIT_LO  = 1 + SLOT_W;
   localparam int MISS_LO = HIT_LO + COUNT_W;

   // response register is empty coming out of reset
   `TLBL_ASSERT_NXT_ALL(a_rst_empty, clock, reset, !rsp_tvalid)
   // stalled response holds
   `TLBL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // the key compare cycle never takes a request
   `TLBL_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // a hit result carries a nonzero hit total
   `TLBL_ASSERT_IMP(a_hit_cnt, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[HIT_LO+COUNT_W-1:HIT_LO] != '0)
   // a miss result carries a nonzero miss total
   `TLBL_ASSERT_IMP(a_miss_cnt, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[MISS_LO+COUNT_W-1:MISS_LO] != '0)

endmodule

bind tlb_lru_lookup_insert_unit tlbl_chk u_tlbl_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/tb_tlb_lru_lookup_insert_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for tlb_lru_lookup_insert_unit: directed and random
// lookup/insert traffic under several entry counts and idle/stall patterns.
// Depends on tlbl_pkg and the unit itself; the scoreboard class holds its own TLB model.

module tb_tlb_lru_lookup_insert_unit;
   import tlbl_pkg::*;

   // request tdata width: page key rounded up to whole bytes
   localparam int REQ_W         = ((KEY_BITS_DEF + 7) / 8) * 8;
   // action codes carried on req_tuser
   localparam logic ACT_LOOKUP  = 1'b0;
   localparam logic ACT_INSERT  = 1'b1;
   // worst case unit latency (insert miss walks the whole chain) plus margin
   localparam int SETTLE_CYCLES = ENTRIES_DEF + 4;
   // cycles with no transfer on either channel before we give up
   localparam int STALL_LIMIT   = 5000;
   localparam int POOL_MAX      = 24;

   // one response, packed as on rsp_tdata: hit in bit 0, then slot,
   // hit count and miss count
   typedef struct packed {
      logic [COUNT_W-1:0] misses;
      logic [COUNT_W-1:0] hits;
      logic [SLOT_W-1:0]  slot;
      logic               hit;
   } tlb_result_t;

   // Scoreboard: tracks keys, use stamps, use clock and running counters,
   // predicts the response of every accepted request and checks responses
   // against those predictions in order.
   class tlb_scoreboard;
      logic [KEY_BITS_DEF-1:0]   entry_key   [ENTRIES_DEF];
      logic [STAMP_BITS_DEF-1:0] entry_stamp [ENTRIES_DEF];
      logic [STAMP_BITS_DEF-1:0] use_clock;
      logic [COUNT_W-1:0]        hit_total;
      logic [COUNT_W-1:0]        miss_total;
      logic [CFG_W-1:0]          entry_limit;
      tlb_result_t               expected_q[$];
      int unsigned               failures;

      function new();
         foreach (entry_key[i]) begin
            entry_key[i]   = '0;
            entry_stamp[i] = '0;
         end
         use_clock   = '0;
         hit_total   = '0;
         miss_total  = '0;
         entry_limit = CFG_RESET;
         failures    = 0;
      endfunction

      function void set_entry_limit(logic [CFG_W-1:0] value);
         entry_limit = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic action, logic [KEY_BITS_DEF-1:0] key);
         tlb_result_t r;
         int          slot_idx;
         int          oldest;
         int          span;
         bit          found;
         bit          empty_seen;

         if (use_clock != '1) use_clock++;

         // lookup covers every valid entry, not only the placement range
         found    = 1'b0;
         slot_idx = 0;
         for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!found && entry_stamp[i] != '0 && entry_key[i] == key) begin
               found    = 1'b1;
               slot_idx = i;
            end
         end

         if (found) begin
            if (hit_total != '1) hit_total++;
            entry_stamp[slot_idx] = use_clock;
         end else begin
            if (miss_total != '1) miss_total++;
            if (action == ACT_INSERT) begin
               // 0 acts as 1, anything above the array size acts as the size
               if (entry_limit == 0)                span = 1;
               else if (entry_limit > ENTRIES_DEF)  span = ENTRIES_DEF;
               else                                 span = entry_limit;
               empty_seen = 1'b0;
               oldest     = 0;
               for (int i = 0; i < span; i++) begin
                  if (!empty_seen) begin
                     if (entry_stamp[i] == '0) begin
                        slot_idx   = i;
                        empty_seen = 1'b1;
                     end else if (entry_stamp[i] < entry_stamp[oldest]) begin
                        oldest = i;
                     end
                  end
               end
               if (!empty_seen) slot_idx = oldest;
               entry_key[slot_idx]   = key;
               entry_stamp[slot_idx] = use_clock;
            end else begin
               slot_idx = 0;
            end
         end

         r.hit    = found;
         r.slot   = slot_idx[SLOT_W-1:0];
         r.hits   = hit_total;
         r.misses = miss_total;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [COUNT_W-1:0] want,
                                  logic [COUNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         tlb_result_t got;
         tlb_result_t want;

         got = data[RSP_FIELDS_W-1:0];
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, actual %h",
                     $time, data);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("hit", COUNT_W'(want.hit), COUNT_W'(got.hit));
         compare_field("slot", COUNT_W'(want.slot), COUNT_W'(got.slot));
         compare_field("hit_count", want.hits, got.hits);
         compare_field("miss_count", want.misses, got.misses);
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every DUT input has a known value at t=0.
   // ---------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata   = '0;   // page_key
   logic                  req_tuser   = 1'b0; // action
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // hit, slot, hit_count, miss_count
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlb_lru_lookup_insert_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tlb_scoreboard sb;
   int            send_idle_pct  = 0;   // chance per cycle that the sender holds off
   int            recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int            quiet_cycles   = 0;

   // Receiver: random backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Response checker. Values sampled at the edge are the pre-edge ones, so
   // the transfer seen here is exactly the one the DUT completes.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus tasks
   // ---------------------------------------------------------------------

   // Present one request and hold it until the transfer. Afterwards the
   // sender may drop valid for a random gap; when it doesn't, valid stays
   // high straight into the next request.
   task automatic send_item(logic action, logic [KEY_BITS_DEF-1:0] key);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= REQ_W'(key);
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, key);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   // Stop sending, wait for every outstanding response, then give the unit
   // its worst-case latency to go quiet before touching the register.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_entry_limit(value);
   endtask

   // 0: free-running, 1: sparse sender, 2: heavy backpressure, 3: light both
   task automatic set_idle(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
         default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
   endtask

   // Random traffic. Most keys come from a small per-phase pool so hits,
   // refreshes and LRU evictions happen often; some keys are fully random.
   task automatic run_random(int count);
      logic [KEY_BITS_DEF-1:0] pool [POOL_MAX];
      logic [KEY_BITS_DEF-1:0] key;
      int                      pool_size;

      pool_size = $urandom_range(4, POOL_MAX);
      foreach (pool[i]) pool[i] = KEY_BITS_DEF'($urandom());
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15) key = KEY_BITS_DEF'($urandom());
         else                            key = pool[$urandom_range(0, pool_size - 1)];
         send_item(logic'($urandom_range(0, 1)), key);
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int   sweep [9];
      logic [CFG_W-1:0] cfg;

      sb = new();
      // entry counts per random phase: zero, all ones, extremes, odd sizes,
      // one above the array size; the last one is drawn at random
      sweep = '{0, 31, 1, 16, 2, 7, 17, 8, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idle(0);

      // Full array. Key 0 must miss on an empty buffer, then live normally.
      csr_write(CFG_RESET);
      send_item(ACT_LOOKUP, 20'h00000);
      send_item(ACT_INSERT, 20'h00000);
      send_item(ACT_LOOKUP, 20'h00000);
      send_item(ACT_INSERT, 20'hFFFFF);
      send_item(ACT_INSERT, 20'h00000);   // refresh of an existing entry
      send_item(ACT_LOOKUP, 20'hFFFFF);
      send_item(ACT_INSERT, 20'h12345);
      send_item(ACT_INSERT, 20'hABCDE);
      send_item(ACT_LOOKUP, 20'h55555);   // plain miss

      // Zero entries acts as one: inserts keep replacing slot 0, while
      // entries above the range still hit.
      settle();
      csr_write(5'd0);
      send_item(ACT_INSERT, 20'h00001);
      send_item(ACT_INSERT, 20'h00002);
      send_item(ACT_LOOKUP, 20'hFFFFF);
      send_item(ACT_LOOKUP, 20'h12345);
      send_item(ACT_LOOKUP, 20'h00001);
      send_item(ACT_INSERT, 20'hABCDE);   // refresh outside placement range

      // Oversized count acts as the full array: fills next empty slots.
      settle();
      csr_write(5'd31);
      send_item(ACT_INSERT, 20'h80000);
      send_item(ACT_INSERT, 20'h40000);

      // Two entries: replacement among slots 0 and 1 by oldest stamp.
      settle();
      csr_write(5'd2);
      send_item(ACT_INSERT, 20'h0F0F0);
      send_item(ACT_INSERT, 20'h70707);
      send_item(ACT_LOOKUP, 20'h70707);
      send_item(ACT_INSERT, 20'h3C3C3);
      send_item(ACT_LOOKUP, 20'h0F0F0);

      // Random phases, cycling through the idle patterns.
      for (int p = 0; p < 9; p++) begin
         settle();
         cfg = (p == 8) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(sweep[p]);
         csr_write(cfg);
         set_idle(p % 4);
         run_random(70);
      end

      settle();
      if (sb.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tlbl_pkg.sv
rtl/core/tlbl_cell.sv
rtl/core/tlb_lru_lookup_insert_unit.sv
rtl/core/tlbl_chk.sv
tb/tb_tlb_lru_lookup_insert_unit.sv
